>>> src/next_fit_heap_allocator_defines.svh
// Assertion macros shared by the checker of the next-fit heap allocator.
// No dependencies; included by the checker file.
`ifndef NEXT_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define NFHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define NFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/nfha_pkg.sv
// Shared constants for the next-fit heap allocator: parameter defaults,
// request kinds and result status codes. No dependencies.
package nfha_pkg;

    // Parameter defaults
    localparam int unsigned HEAP_UNITS_DEF    = 1024;
    localparam int unsigned GRANULE_BYTES_DEF = 64;
    localparam int unsigned HEADER_BYTES_DEF  = 8;

    // Request kinds (carried on tuser)
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes (carried on tuser)
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;
    localparam logic [1:0] ST_CORRUPT = 2'd3;

    // Field widths
    localparam int unsigned BYTES_W  = 16;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned STATUS_W = 2;

endpackage

>>> src/nfha_cdiv.sv
// Three-stage divider by a constant: reciprocal multiply, back-multiply,
// single correction step. Depends on nothing but its parameters.
module nfha_cdiv #(
    parameter int unsigned XW      = 17,
    parameter int unsigned DIVISOR = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [XW-1:0] i_x,
    output logic          o_valid,
    output logic [XW-1:0] o_q
);

    // floor(2^XW / DIVISOR): estimate is at most one below the true quotient
    localparam logic [XW-1:0] RECIP = XW'((2 ** XW) / DIVISOR);
    localparam logic [XW-1:0] DIV_V = XW'(DIVISOR);

    logic [2:0]      r_vld;
    logic [2*XW-1:0] r_prod;
    logic [XW-1:0]   r_x1;
    logic [XW-1:0]   r_x2;
    logic [XW-1:0]   r_q0;
    logic [2*XW-1:0] r_qg;
    logic [XW-1:0]   r_q;
    logic [XW-1:0]   q_est;
    logic [XW-1:0]   rem;

    assign q_est = r_prod[2*XW-1:XW];
    assign rem   = r_x2 - r_qg[XW-1:0];

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_prod <= {{XW{1'b0}}, i_x} * {{XW{1'b0}}, RECIP};
        r_x1   <= i_x;
        r_q0   <= q_est;
        r_qg   <= {{XW{1'b0}}, q_est} * {{XW{1'b0}}, DIV_V};
        r_x2   <= r_x1;
        r_q    <= (rem >= DIV_V) ? r_q0 + XW'(1) : r_q0;
    end

    assign o_valid = r_vld[2];
    assign o_q     = r_q;

endmodule

>>> src/next_fit_heap_allocator.sv
// Next-fit heap allocator over an implicit list of block headers held in
// one synchronous RAM. Uses nfha_pkg and the constant divider nfha_cdiv.
//
// Usage:
//   Requests arrive on the slave stream (i_s_*): tuser is the kind
//   (0 allocate, 1 free), tdata carries alloc_bytes in [15:0] and free_addr
//   in [31:16]. Each request yields exactly one result on the master stream
//   (o_m_*): tdata is the payload byte offset (0 unless an allocate
//   succeeded), tuser the status (ok, out of memory, null free, corrupt).
//   Requests are served one at a time; o_s_tready is high only while the
//   block waits for work, and it rises as the result is loaded.
//   Steps: the constant divider sizes the request, the scan or the merge
//   visits one header per cycle, the header write-back writes up to two
//   headers and the result is loaded into the output register; a free below
//   the header size skips to the result. The RAM read address follows from
//   the header just read, hence one header a cycle.
//   Reset: the heap reads as one free block of HEAP_UNITS units and the
//   next-fit pointer is unit 0; no clearing pass is needed.
//   Stall: a result waits in the output register until taken; the next
//   request is accepted meanwhile, its result held until the register is free.
module next_fit_heap_allocator #(
    parameter int unsigned HEAP_UNITS    = nfha_pkg::HEAP_UNITS_DEF,
    parameter int unsigned GRANULE_BYTES = nfha_pkg::GRANULE_BYTES_DEF,
    parameter int unsigned HEADER_BYTES  = nfha_pkg::HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [15:0] alloc_bytes, [31:16] free_addr
    input  logic        i_s_tuser,  // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [15:0] addr
    output logic [1:0]  o_m_tuser   // [1:0] status
);

    // Widths derived from the parameters
    localparam int unsigned AW = $clog2(HEAP_UNITS);
    localparam int unsigned SW = $clog2(HEAP_UNITS + 1);
    localparam int unsigned HW = SW + 1;
    localparam int unsigned XW = $clog2(65536 + HEADER_BYTES + GRANULE_BYTES);

    localparam logic [SW-1:0] HEAP_S  = SW'(HEAP_UNITS);
    localparam logic [SW:0]   HEAP_S1 = (SW + 1)'(HEAP_UNITS);
    localparam logic [XW-1:0] HEAP_X  = XW'(HEAP_UNITS);
    localparam logic [XW-1:0] ROUND_X = XW'(HEADER_BYTES + GRANULE_BYTES - 1);
    localparam logic [XW-1:0] HDR_X   = XW'(HEADER_BYTES);
    localparam logic [15:0]   HDR_A   = 16'(HEADER_BYTES);

    // State codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_AWR1   = 4'd3;
    localparam logic [3:0] S_AWR2   = 4'd4;
    localparam logic [3:0] S_FHEAD  = 4'd5;
    localparam logic [3:0] S_FMERGE = 4'd6;
    localparam logic [3:0] S_FWR    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // Header RAM and read port
    logic [HW-1:0] r_hdr_mem [HEAP_UNITS];
    logic [HW-1:0] r_rd_data;
    logic          r_rd_dflt;
    logic          r_e0_written;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [HW-1:0] wr_data;
    logic [HW-1:0] hdr;
    logic          hdr_busy;
    logic [SW-1:0] hdr_size;

    // Control and working registers
    logic [3:0]    r_state, n_state;
    logic          r_req, n_req;
    logic [AW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_need, n_need;
    logic [SW-1:0] r_size, n_size;
    logic [SW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_nx, n_nx;
    logic [SW-1:0] r_nfp, n_nfp;
    logic [15:0]   r_res_addr, n_res_addr;
    logic [1:0]    r_res_status, n_res_status;
    logic          r_ovalid, n_ovalid;
    logic [15:0]   r_out_addr;
    logic [1:0]    r_out_status;
    logic          out_load;

    // Divider interface
    logic          div_valid;
    logic [XW-1:0] div_x;
    logic          div_q_valid;
    logic [XW-1:0] div_q;

    // Scratch arithmetic
    logic [SW:0]   walk_nxt;
    logic [SW-1:0] start_cur;
    logic [SW-1:0] need_q;
    logic [31:0]   addr_full;
    logic          req_in;
    logic [15:0]   bytes_in;
    logic [15:0]   faddr_in;

    assign req_in   = i_s_tuser;
    assign bytes_in = i_s_tdata[15:0];
    assign faddr_in = i_s_tdata[31:16];

    // Unwritten entry 0 reads as the whole free heap
    assign hdr      = r_rd_dflt ? {1'b0, HEAP_S} : r_rd_data;
    assign hdr_busy = hdr[HW-1];
    assign hdr_size = hdr[SW-1:0];

    assign need_q    = div_q[SW-1:0];
    assign start_cur = (r_nfp > (HEAP_S - need_q)) ? '0 : r_nfp;
    assign addr_full = 32'(r_cur) * 32'(GRANULE_BYTES) + 32'(HEADER_BYTES);

    // Request sizing: payload plus header rounded up, or free offset to unit
    assign div_x = (req_in == nfha_pkg::REQ_FREE) ? (XW'(faddr_in) - HDR_X)
                                                  : (XW'(bytes_in) + ROUND_X);

    nfha_cdiv #(
        .XW      (XW),
        .DIVISOR (GRANULE_BYTES)
    ) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_x     (div_x),
        .o_valid (div_q_valid),
        .o_q     (div_q)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_cur        = r_cur;
        n_need       = r_need;
        n_size       = r_size;
        n_acc        = r_acc;
        n_nx         = r_nx;
        n_nfp        = r_nfp;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_ovalid     = r_ovalid && !i_m_tready;
        out_load     = 1'b0;
        div_valid    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        walk_nxt     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_req        = req_in;
                    n_res_addr   = '0;
                    n_res_status = nfha_pkg::ST_OK;
                    if (req_in == nfha_pkg::REQ_FREE && faddr_in < HDR_A) begin
                        n_res_status = nfha_pkg::ST_NULL;
                        n_state      = S_DONE;
                    end else begin
                        div_valid = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end

            S_DIV: begin
                if (div_q_valid) begin
                    if (r_req == nfha_pkg::REQ_ALLOC) begin
                        if (div_q > HEAP_X) begin
                            n_res_status = nfha_pkg::ST_NOMEM;
                            n_state      = S_DONE;
                        end else begin
                            n_need  = need_q;
                            n_cur   = start_cur[AW-1:0];
                            rd_en   = 1'b1;
                            rd_addr = start_cur[AW-1:0];
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (div_q >= HEAP_X) begin
                            n_res_status = nfha_pkg::ST_NULL;
                            n_state      = S_DONE;
                        end else begin
                            n_cur   = div_q[AW-1:0];
                            rd_en   = 1'b1;
                            rd_addr = div_q[AW-1:0];
                            n_state = S_FHEAD;
                        end
                    end
                end
            end

            // Allocate walk: one header per cycle
            S_SCAN: begin
                walk_nxt = (SW + 1)'(r_cur) + (SW + 1)'(hdr_size);
                if (hdr_size == '0) begin
                    n_res_status = nfha_pkg::ST_CORRUPT;
                    n_state      = S_DONE;
                end else if (!hdr_busy && hdr_size >= r_need) begin
                    n_size  = hdr_size;
                    n_state = S_AWR1;
                end else if (walk_nxt >= HEAP_S1) begin
                    n_res_status = nfha_pkg::ST_NOMEM;
                    n_state      = S_DONE;
                end else begin
                    n_cur   = walk_nxt[AW-1:0];
                    rd_en   = 1'b1;
                    rd_addr = walk_nxt[AW-1:0];
                end
            end

            // Mark the block busy, trimmed to the request when it splits
            S_AWR1: begin
                wr_en      = 1'b1;
                wr_addr    = r_cur;
                n_res_addr = addr_full[15:0];
                if (r_size != r_need) begin
                    wr_data = {1'b1, r_need};
                    n_state = S_AWR2;
                end else begin
                    wr_data = {1'b1, r_size};
                    n_nfp   = SW'(r_cur) + r_size;
                    n_state = S_DONE;
                end
            end

            // Header of the split-off remainder
            S_AWR2: begin
                wr_en   = 1'b1;
                wr_addr = r_cur + AW'(r_need);
                wr_data = {1'b0, r_size - r_need};
                n_nfp   = SW'(r_cur) + r_need;
                n_state = S_DONE;
            end

            // Freed block's own header
            S_FHEAD: begin
                walk_nxt = (SW + 1)'(r_cur) + (SW + 1)'(hdr_size);
                n_acc    = hdr_size;
                if (hdr_size == '0) begin
                    n_res_status = nfha_pkg::ST_CORRUPT;
                    n_state      = S_FWR;
                end else if (walk_nxt >= HEAP_S1) begin
                    n_state = S_FWR;
                end else begin
                    n_nx    = walk_nxt[AW-1:0];
                    rd_en   = 1'b1;
                    rd_addr = walk_nxt[AW-1:0];
                    n_state = S_FMERGE;
                end
            end

            // Merge following free blocks, one per cycle
            S_FMERGE: begin
                walk_nxt = (SW + 1)'(r_nx) + (SW + 1)'(hdr_size);
                if (hdr_busy) begin
                    n_state = S_FWR;
                end else if (hdr_size == '0) begin
                    n_res_status = nfha_pkg::ST_CORRUPT;
                    n_state      = S_FWR;
                end else begin
                    n_acc = r_acc + hdr_size;
                    if (walk_nxt >= HEAP_S1) begin
                        n_state = S_FWR;
                    end else begin
                        n_nx    = walk_nxt[AW-1:0];
                        rd_en   = 1'b1;
                        rd_addr = walk_nxt[AW-1:0];
                    end
                end
            end

            // Write back the merged free block
            S_FWR: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = {1'b0, r_acc};
                if (r_res_status == nfha_pkg::ST_OK && SW'(r_cur) < r_nfp) begin
                    n_nfp = SW'(r_cur);
                end
                n_state = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nfp        <= '0;
            r_ovalid     <= 1'b0;
            r_e0_written <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nfp    <= n_nfp;
            r_ovalid <= n_ovalid;
            if (wr_en && wr_addr == '0) begin
                r_e0_written <= 1'b1;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_cur        <= n_cur;
        r_need       <= n_need;
        r_size       <= n_size;
        r_acc        <= n_acc;
        r_nx         <= n_nx;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    // Header RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hdr_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_hdr_mem[rd_addr];
            r_rd_dflt <= (rd_addr == '0) && !r_e0_written;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out_addr;
    assign o_m_tuser  = r_out_status;

endmodule

>>> src/nfha_chk.sv
// Port-level checker for the next-fit heap allocator, bound to the top level.
// Uses nfha_pkg and the macros of next_fit_heap_allocator_defines.svh.
`include "next_fit_heap_allocator_defines.svh"

module nfha_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    logic in_xfer;

    assign in_xfer = i_s_tvalid && o_s_tready;

    // A stalled result holds its value
    `NFHA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    // Only a successful allocate carries a non-zero offset
    `NFHA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != nfha_pkg::ST_OK, o_m_tdata == 16'd0, "failed request returned an offset")

    // One request in work at a time: input closes after a transfer
    `NFHA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_xfer, !o_s_tready, "input open while a request is in work")

    // No result straight out of reset
    `NFHA_ASSERT_IMPL(a_reset_quiet, i_clk, i_rst_n, !$past(i_rst_n), !o_m_tvalid, "result valid after reset")

endmodule

bind next_fit_heap_allocator nfha_chk u_nfha_chk (.*);

>>> sim/heap_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the next-fit heap allocator: keeps its own copy of the
// block headers and the next-fit pointer, predicts one result per request and
// compares it with what the block returns. Depends on nfha_pkg.
module heap_result_checker #(
    parameter int unsigned HEAP_UNITS    = nfha_pkg::HEAP_UNITS_DEF,
    parameter int unsigned GRANULE_BYTES = nfha_pkg::GRANULE_BYTES_DEF,
    parameter int unsigned HEADER_BYTES  = nfha_pkg::HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,  // [15:0] alloc_bytes, [31:16] free_addr
    input  logic        i_s_tuser,  // [0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,  // [15:0] addr
    input  logic [1:0]  i_m_tuser,  // [1:0] status
    output int          o_mismatches,
    output int          o_pending,
    output int          o_alloc_granted,
    output int          o_alloc_refused,
    output int          o_free_done,
    output int          o_free_null
);

    localparam int SIZE_W = $clog2(HEAP_UNITS) + 1;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_heap_result;

    // Shadow heap: one header per unit, plus the next-fit pointer
    bit [SIZE_W-1:0] unit_size [HEAP_UNITS];
    bit              unit_busy [HEAP_UNITS];
    bit [SIZE_W-1:0] next_fit;

    t_heap_result expected_results [$];
    int           mismatch_count;

    // Work out the result of one request and update the shadow heap
    task automatic predict_heap_request(input logic kind, input logic [15:0] bytes,
                                        input logic [15:0] faddr,
                                        output t_heap_result res);
        int unsigned need;
        int unsigned cur;
        int unsigned nx;
        bit          done;
        res.addr   = '0;
        res.status = nfha_pkg::ST_OK;
        if (kind == nfha_pkg::REQ_ALLOC) begin
            need = (bytes + HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
            if (need > HEAP_UNITS) begin
                res.status = nfha_pkg::ST_NOMEM;
            end else begin
                // start at the pointer unless the request cannot fit past it
                cur  = (next_fit > HEAP_UNITS - need) ? 0 : next_fit;
                done = 1'b0;
                while (!done) begin
                    if (cur >= HEAP_UNITS) begin
                        res.status = nfha_pkg::ST_NOMEM;
                        done       = 1'b1;
                    end else if (unit_size[cur] == 0) begin
                        res.status = nfha_pkg::ST_CORRUPT;
                        done       = 1'b1;
                    end else if (!unit_busy[cur] && unit_size[cur] >= need) begin
                        done = 1'b1;
                    end else begin
                        cur += unit_size[cur];
                    end
                end
                if (res.status == nfha_pkg::ST_OK) begin
                    // split off any spare units as a new free block
                    if (unit_size[cur] > need) begin
                        unit_size[cur+need] = unit_size[cur] - SIZE_W'(need);
                        unit_busy[cur+need] = 1'b0;
                        unit_size[cur]      = SIZE_W'(need);
                        next_fit            = SIZE_W'(cur + need);
                    end else begin
                        next_fit = SIZE_W'(cur + unit_size[cur]);
                    end
                    unit_busy[cur] = 1'b1;
                    res.addr       = 16'(cur * GRANULE_BYTES + HEADER_BYTES);
                end
            end
            if (res.status == nfha_pkg::ST_OK) o_alloc_granted++;
            else o_alloc_refused++;
        end else begin
            if (faddr < HEADER_BYTES) begin
                res.status = nfha_pkg::ST_NULL;
            end else begin
                cur = (faddr - HEADER_BYTES) / GRANULE_BYTES;
                if (cur >= HEAP_UNITS) begin
                    res.status = nfha_pkg::ST_NULL;
                end else begin
                    // release, then absorb the free blocks that follow
                    unit_busy[cur] = 1'b0;
                    done           = 1'b0;
                    while (!done) begin
                        nx = cur + unit_size[cur];
                        if (nx >= HEAP_UNITS || unit_busy[nx]) begin
                            done = 1'b1;
                        end else if (unit_size[nx] == 0) begin
                            res.status = nfha_pkg::ST_CORRUPT;
                            done       = 1'b1;
                        end else begin
                            unit_size[cur] += unit_size[nx];
                        end
                    end
                    if (res.status == nfha_pkg::ST_OK && cur < next_fit)
                        next_fit = SIZE_W'(cur);
                end
            end
            if (res.status == nfha_pkg::ST_NULL) o_free_null++;
            else if (res.status == nfha_pkg::ST_OK) o_free_done++;
        end
    endtask

    // Watch both channels at every rising edge
    always @(posedge i_clk) begin : watch
        t_heap_result exp_res;
        t_heap_result got_res;
        if (!i_rst_n) begin
            for (int u = 0; u < HEAP_UNITS; u++) begin
                unit_size[u] = '0;
                unit_busy[u] = 1'b0;
            end
            unit_size[0]    = SIZE_W'(HEAP_UNITS);
            next_fit        = '0;
            expected_results.delete();
            mismatch_count  = 0;
            o_alloc_granted = 0;
            o_alloc_refused = 0;
            o_free_done     = 0;
            o_free_null     = 0;
        end else begin
            // request transfer: predict its result
            if (i_s_tvalid && i_s_tready) begin
                predict_heap_request(i_s_tuser, i_s_tdata[15:0], i_s_tdata[31:16], exp_res);
                expected_results.push_back(exp_res);
            end
            // result transfer: compare with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got_res.addr   = i_m_tdata;
                got_res.status = i_m_tuser;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result with nothing expected: addr %0d status %0d",
                                 $realtime, got_res.addr, got_res.status);
                    mismatch_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got_res.addr !== exp_res.addr || got_res.status !== exp_res.status) begin
                        if (mismatch_count < 10)
                            $display("%0t: mismatch: addr exp %0d got %0d, status exp %0d got %0d",
                                     $realtime, exp_res.addr, got_res.addr,
                                     exp_res.status, got_res.status);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_results.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the next-fit heap allocator: drives allocate and free
// requests with random gaps and stalls and gives the verdict. Depends on
// nfha_pkg, next_fit_heap_allocator and heap_result_checker.
module tb;

    localparam int unsigned UNITS = nfha_pkg::HEAP_UNITS_DEF;
    localparam int unsigned GRAN  = nfha_pkg::GRANULE_BYTES_DEF;
    localparam int unsigned HDR   = nfha_pkg::HEADER_BYTES_DEF;
    localparam int          RANDOM_ITEMS = 450;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;  // [15:0] alloc_bytes, [31:16] free_addr
    logic        i_s_tuser;  // [0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;  // [15:0] addr
    logic [1:0]  o_m_tuser;  // [1:0] status

    int mismatches, pending, alloc_granted, alloc_refused, free_done, free_null;

    // Bookkeeping for stimulus: units needed per request in flight, payload
    // addresses handed out, and units whose header has been written
    int unsigned     units_in_flight [$];
    logic [15:0]     live_addrs [$];
    int unsigned     header_units [$];
    bit              header_seen [UNITS];
    bit              send_burst;
    bit              take_burst;
    int              results_taken;

    next_fit_heap_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    heap_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tuser       (o_m_tuser),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_alloc_granted (alloc_granted),
        .o_alloc_refused (alloc_refused),
        .o_free_done     (free_done),
        .o_free_null     (free_null)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned units_for(input logic [15:0] bytes);
        return (bytes + HDR + GRAN - 1) / GRAN;
    endfunction

    function automatic logic [15:0] clamp_addr(input int unsigned a);
        return (a > 16'hFFFF) ? 16'hFFFF : a[15:0];
    endfunction

    task automatic note_header(input int unsigned unit);
        if (unit < UNITS && !header_seen[unit]) begin
            header_seen[unit] = 1'b1;
            header_units.push_back(unit);
        end
    endtask

    // One request transfer, after a random gap; called and left at a falling edge
    task automatic send_request(input logic kind, input logic [15:0] bytes,
                                input logic [15:0] faddr);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {faddr, bytes};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        units_in_flight.push_back(kind == nfha_pkg::REQ_ALLOC ? units_for(bytes) : 0);
        @(negedge i_clk);
    endtask

    // Hold requests back until every result is in
    task automatic wait_drained(input int limit);
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 && waited < limit) begin
            @(negedge i_clk);
            waited++;
        end
    endtask

    // Free address: mostly a live block, some stale or repeated headers, some null
    task automatic pick_free_addr(output logic [15:0] faddr);
        int r;
        int idx;
        int unsigned base;
        r = $urandom_range(0, 99);
        if (r < 70 && live_addrs.size() > 0) begin
            idx  = $urandom_range(0, live_addrs.size() - 1);
            base = live_addrs[idx];
            live_addrs.delete(idx);
            if ($urandom_range(0, 3) == 0) base += $urandom_range(0, GRAN - 1);
            faddr = clamp_addr(base);
        end else if (r < 92 && header_units.size() > 0) begin
            base  = header_units[$urandom_range(0, header_units.size() - 1)] * GRAN + HDR;
            faddr = clamp_addr(base + $urandom_range(0, GRAN - 1));
        end else begin
            faddr = 16'($urandom_range(0, HDR - 1));
        end
    endtask

    function automatic logic [15:0] pick_alloc_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 1500));
        if (r < 90) return 16'($urandom_range(0, 8000));
        if (r < 97) return 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'd65528;  // whole heap exactly
            2: return 16'd65529;  // one unit over the heap
            default: return 16'hFFFF;
        endcase
    endfunction

    // Result side: random stalls, one long hold-off, address bookkeeping
    initial begin : result_side
        int hold;
        int unsigned need;
        int unsigned unit;
        bit long_hold_done;
        i_m_tready     = 1'b0;
        take_burst     = 1'b0;
        results_taken  = 0;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (results_taken % 40 == 0) take_burst = ($urandom_range(0, 3) == 0);
            hold = take_burst ? 0 : $urandom_range(0, 18);
            if (!long_hold_done && results_taken == 60) begin
                hold           = 400;
                long_hold_done = 1'b1;
            end
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            results_taken++;
            if (units_in_flight.size() > 0) begin
                need = units_in_flight.pop_front();
                if (need > 0 && o_m_tuser == nfha_pkg::ST_OK && o_m_tdata >= HDR) begin
                    unit = (o_m_tdata - HDR) / GRAN;
                    note_header(unit);
                    note_header(unit + need);
                    live_addrs.push_back(o_m_tdata);
                end
            end
            @(negedge i_clk);
        end
    end

    // Request side and verdict
    initial begin : request_side
        int          useful;
        int          sent;
        logic [15:0] bytes;
        logic [15:0] faddr;
        bit          do_alloc;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = nfha_pkg::REQ_ALLOC;
        send_burst = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: addresses follow from the heap layout after reset
        send_request(nfha_pkg::REQ_ALLOC, 16'd0,     16'hFFFF);  // smallest request
        send_request(nfha_pkg::REQ_ALLOC, 16'd56,    16'h0000);  // fills one unit exactly
        send_request(nfha_pkg::REQ_ALLOC, 16'd57,    16'hAAAA);  // spills into a second unit
        send_request(nfha_pkg::REQ_ALLOC, 16'hFFFF,  16'h5555);  // oversized
        send_request(nfha_pkg::REQ_ALLOC, 16'd65529, 16'h0000);  // one unit over the heap
        send_request(nfha_pkg::REQ_ALLOC, 16'd65528, 16'h0000);  // fits nowhere, hits the end
        send_request(nfha_pkg::REQ_FREE,  16'hFFFF,  16'd0);     // null free
        send_request(nfha_pkg::REQ_FREE,  16'h0000,  16'd7);     // just below the header size
        send_request(nfha_pkg::REQ_FREE,  16'h1234,  16'd135);   // unaligned free of unit 1
        send_request(nfha_pkg::REQ_FREE,  16'h0000,  16'd8);     // unit 0, merges unit 1
        send_request(nfha_pkg::REQ_FREE,  16'hFFFF,  16'd8);     // double free
        send_request(nfha_pkg::REQ_ALLOC, 16'd100,   16'h0000);  // exact reuse of merged block
        send_request(nfha_pkg::REQ_ALLOC, 16'd65272, 16'h0000);  // takes the rest
        send_request(nfha_pkg::REQ_ALLOC, 16'd0,     16'h0000);  // heap full
        send_request(nfha_pkg::REQ_FREE,  16'h0000,  16'd327);   // last block, unaligned
        send_request(nfha_pkg::REQ_FREE,  16'h0000,  16'd136);   // merges into the tail
        send_request(nfha_pkg::REQ_FREE,  16'h0000,  16'd8);     // heap whole again
        send_request(nfha_pkg::REQ_ALLOC, 16'd65528, 16'h0000);  // whole heap in one block
        send_request(nfha_pkg::REQ_FREE,  16'h0000,  16'd71);    // release it
        wait_drained(100_000);
        live_addrs.delete();

        // Random part: null frees do not count towards the item total
        useful = 0;
        sent   = 0;
        while (useful < RANDOM_ITEMS) begin
            if (sent % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
            if (sent == 225) wait_drained(100_000);
            do_alloc = (live_addrs.size() < 30) ? ($urandom_range(0, 99) < 60)
                                                : ($urandom_range(0, 99) < 40);
            if (do_alloc) begin
                bytes = pick_alloc_bytes();
                send_request(nfha_pkg::REQ_ALLOC, bytes, 16'($urandom_range(0, 65535)));
                useful++;
            end else begin
                pick_free_addr(faddr);
                send_request(nfha_pkg::REQ_FREE, 16'($urandom_range(0, 65535)), faddr);
                if (faddr >= HDR) useful++;
            end
            sent++;
        end

        // Drain, then allow the block's own latency
        wait_drained(200_000);
        repeat (64) @(negedge i_clk);

        $display("Requests: %0d allocations granted, %0d refused; %0d frees, %0d null frees.",
                 alloc_granted, alloc_refused, free_done, free_null);
        $display("Results left unmatched: %0d, mismatching or unexpected results: %0d.",
                 pending, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/nfha_pkg.sv
src/nfha_cdiv.sv
src/next_fit_heap_allocator.sv
src/nfha_chk.sv
sim/heap_result_checker.sv
sim/tb.sv
